// ===== sv/sbfc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and checksum helper for the spa bus frame controller
package sbfc_pkg;

    localparam int QUEUE_DEPTH = 2;

    // bus bytes
    localparam logic [7:0] START_BYTE  = 8'hA5;
    localparam logic [7:0] STATUS_NONE = 8'hFF;

    // received commands that update status
    localparam logic [7:0] CMD_TEMP   = 8'h06;
    localparam logic [7:0] CMD_BATH   = 8'h08;
    localparam logic [7:0] CMD_STAT_A = 8'h12;
    localparam logic [7:0] CMD_STAT_B = 8'h18;
    localparam logic [7:0] CMD_STAT_C = 8'h1A;

    // transmitted commands
    localparam logic [7:0] CMD_HEATER  = 8'h01;
    localparam logic [7:0] CMD_FILTER  = 8'h02;
    localparam logic [7:0] CMD_BUBBLES = 8'h03;
    localparam logic [7:0] CMD_TARGET  = 8'h04;
    localparam logic [7:0] CMD_BEAT    = 8'h16;

    // request kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_HOLD = 1'b1;

    // result kinds
    localparam logic OUT_KIND_REPORT = 1'b0;
    localparam logic OUT_KIND_TX     = 1'b1;

    // register indexes
    localparam logic [2:0] REG_TX_EN       = 3'd0;
    localparam logic [2:0] REG_HOLD_EN     = 3'd1;
    localparam logic [2:0] REG_TARGET_EN   = 3'd2;
    localparam logic [2:0] REG_BEAT_EN     = 3'd3;
    localparam logic [2:0] REG_WANT_FILTER = 3'd4;
    localparam logic [2:0] REG_WANT_HEATER = 3'd5;
    localparam logic [2:0] REG_WANT_BUBBLE = 3'd6;
    localparam logic [2:0] REG_TARGET_C    = 3'd7;

    localparam logic [6:0] TARGET_RESET = 7'd38;

    typedef struct packed {
        logic       tx_en;
        logic       hold_en;
        logic       target_en;
        logic       beat_en;
        logic       want_filter;
        logic       want_heater;
        logic [7:0] want_bubbles;
        logic [6:0] target_celsius;
    } cfg_t;

    typedef struct packed {
        logic [7:0] temp;
        logic       temp_known;
        logic [7:0] bath;
        logic [7:0] stat_a;
        logic [7:0] stat_b;
        logic [7:0] stat_c;
    } status_t;

    typedef struct packed {
        logic       is_hold;
        logic [7:0] cmd;
        logic [7:0] value;
        logic [7:0] check;
        logic       ok;
        logic       heater;
        status_t    status;
    } job_t;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] cmd;
        logic [7:0] value;
        logic [7:0] check;
        logic       ok;
        logic       last;
        status_t    status;
    } res_t;

    function automatic logic [7:0] frame_sum(input logic [7:0] cmd, input logic [7:0] val);
        frame_sum = START_BYTE + cmd + val;
    endfunction

endpackage

// ===== sv/sbfc_front.sv =====
`timescale 1ns / 1ps
// front end: deframes bus bytes, tracks status, turns requests into jobs
module sbfc_front import sbfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] rx_byte,
    input  cfg_t       cfg,
    input  logic       q_full,
    output logic       q_push,
    output job_t       q_job
);

    typedef enum logic [3:0] {
        FP_HUNT  = 4'b0001,
        FP_CMD   = 4'b0010,
        FP_VALUE = 4'b0100,
        FP_CHECK = 4'b1000
    } fpos_t;

    fpos_t      fpos_reg, fpos_next;
    logic [7:0] held_cmd_reg, held_cmd_next;
    logic [7:0] held_value_reg, held_value_next;
    status_t    stat_reg, stat_next;
    logic       accept;
    logic       sum_ok;
    logic       needs_heat;
    logic       filter;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign sum_ok   = (frame_sum(held_cmd_reg, held_value_reg) == rx_byte);
    assign filter   = cfg.want_filter || cfg.want_heater || (cfg.want_bubbles != 8'd0);
    assign needs_heat = !stat_reg.temp_known || (stat_reg.temp < {cfg.target_celsius, 1'b0});

    always_comb
    begin
        fpos_next       = fpos_reg;
        held_cmd_next   = held_cmd_reg;
        held_value_next = held_value_reg;
        stat_next       = stat_reg;
        q_push          = 1'b0;
        q_job           = '0;
        if (accept)
        begin
            if (kind == KIND_BYTE)
            begin
                if (rx_byte == START_BYTE)
                begin
                    fpos_next = FP_CMD;
                end
                else
                begin
                    unique case (fpos_reg)
                        FP_HUNT:
                        begin
                            fpos_next = FP_HUNT;
                        end
                        FP_CMD:
                        begin
                            held_cmd_next = rx_byte;
                            fpos_next     = FP_VALUE;
                        end
                        FP_VALUE:
                        begin
                            held_value_next = rx_byte;
                            fpos_next       = FP_CHECK;
                        end
                        FP_CHECK:
                        begin
                            fpos_next   = FP_HUNT;
                            q_push      = 1'b1;
                            q_job.cmd   = held_cmd_reg;
                            q_job.value = held_value_reg;
                            q_job.check = rx_byte;
                            q_job.ok    = sum_ok;
                            if (sum_ok)
                            begin
                                unique case (held_cmd_reg)
                                    CMD_TEMP:
                                    begin
                                        stat_next.temp       = held_value_reg;
                                        stat_next.temp_known = 1'b1;
                                    end
                                    CMD_BATH:   stat_next.bath   = held_value_reg;
                                    CMD_STAT_A: stat_next.stat_a = held_value_reg;
                                    CMD_STAT_B: stat_next.stat_b = held_value_reg;
                                    CMD_STAT_C: stat_next.stat_c = held_value_reg;
                                    default:    stat_next        = stat_reg;
                                endcase
                            end
                        end
                        default:
                        begin
                            fpos_next = FP_HUNT;
                        end
                    endcase
                end
            end
            else if (cfg.tx_en && cfg.hold_en)
            begin
                q_push        = 1'b1;
                q_job.is_hold = 1'b1;
                q_job.heater  = cfg.want_heater && filter && needs_heat;
            end
        end
        q_job.status = stat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fpos_reg          <= FP_HUNT;
            held_cmd_reg      <= 8'd0;
            held_value_reg    <= 8'd0;
            stat_reg.temp       <= 8'd0;
            stat_reg.temp_known <= 1'b0;
            stat_reg.bath       <= STATUS_NONE;
            stat_reg.stat_a     <= STATUS_NONE;
            stat_reg.stat_b     <= STATUS_NONE;
            stat_reg.stat_c     <= STATUS_NONE;
        end
        else
        begin
            fpos_reg       <= fpos_next;
            held_cmd_reg   <= held_cmd_next;
            held_value_reg <= held_value_next;
            stat_reg       <= stat_next;
        end
    end

endmodule

// ===== sv/sbfc_queue.sv =====
`timescale 1ns / 1ps
// short job queue between front end and back end
module sbfc_queue import sbfc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== sv/sbfc_back.sv =====
`timescale 1ns / 1ps
// back end: expands jobs into result frames through an output register
module sbfc_back import sbfc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic empty,
    input  job_t head_job,
    output logic pop,
    output logic out_valid,
    input  logic out_stall,
    output res_t res
);

    typedef enum logic [4:0] {
        ST_FILTER  = 5'b00001,
        ST_HEATER  = 5'b00010,
        ST_BUBBLES = 5'b00100,
        ST_TARGET  = 5'b01000,
        ST_BEAT    = 5'b10000
    } tx_step_t;

    tx_step_t   step_reg, step_next, step_after;
    logic       out_valid_reg, out_valid_next;
    res_t       res_reg, res_next;
    logic       load;
    logic       take;
    logic       filter;
    logic       last;
    logic [7:0] cmd;
    logic [7:0] value;

    assign load   = !out_valid_reg || !out_stall;
    assign take   = load && !empty;
    assign filter = cfg.want_filter || cfg.want_heater || (cfg.want_bubbles != 8'd0);

    // pick the frame for the current step of a hold job
    always_comb
    begin
        cmd        = CMD_FILTER;
        value      = {7'd0, filter};
        last       = 1'b0;
        step_after = ST_FILTER;
        unique case (step_reg)
            ST_FILTER:
            begin
                cmd        = CMD_FILTER;
                value      = {7'd0, filter};
                step_after = ST_HEATER;
            end
            ST_HEATER:
            begin
                cmd        = CMD_HEATER;
                value      = {7'd0, head_job.heater};
                step_after = ST_BUBBLES;
            end
            ST_BUBBLES:
            begin
                cmd        = CMD_BUBBLES;
                value      = cfg.want_bubbles;
                last       = !cfg.target_en && !cfg.beat_en;
                step_after = cfg.target_en ? ST_TARGET : ST_BEAT;
            end
            ST_TARGET:
            begin
                cmd        = CMD_TARGET;
                value      = {1'b0, cfg.target_celsius};
                last       = !cfg.beat_en;
                step_after = ST_BEAT;
            end
            ST_BEAT:
            begin
                cmd        = CMD_BEAT;
                value      = 8'd0;
                last       = 1'b1;
                step_after = ST_FILTER;
            end
            default:
            begin
                step_after = ST_FILTER;
            end
        endcase
    end

    always_comb
    begin
        res_next        = res_reg;
        step_next       = step_reg;
        pop             = 1'b0;
        out_valid_next  = out_valid_reg;
        if (load)
        begin
            out_valid_next = !empty;
        end
        if (take)
        begin
            res_next.status = head_job.status;
            if (head_job.is_hold)
            begin
                res_next.out_kind = OUT_KIND_TX;
                res_next.cmd      = cmd;
                res_next.value    = value;
                res_next.check    = frame_sum(cmd, value);
                res_next.ok       = 1'b1;
                res_next.last     = last;
                pop               = last;
                step_next         = last ? ST_FILTER : step_after;
            end
            else
            begin
                res_next.out_kind = OUT_KIND_REPORT;
                res_next.cmd      = head_job.cmd;
                res_next.value    = head_job.value;
                res_next.check    = head_job.check;
                res_next.ok       = head_job.ok;
                res_next.last     = 1'b1;
                pop               = 1'b1;
                step_next         = ST_FILTER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_FILTER;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

// ===== sv/spa_bus_frame_controller.sv =====
`timescale 1ns / 1ps
// spa bus frame controller: bus byte deframing and hold frame generation
// enabled holds and checksum bytes become queued jobs; results leave the output register
// throughput: one request a cycle while the job queue has room; the back end sends
//   one result a cycle unless stalled; a hold job yields 3 to 5 results, a report 1
// the job queue holds QUEUE_DEPTH jobs; the back end sequencer sets the sustained rate
// reset (rst_n low, asynchronous): framer hunts for start, status bytes 0xff, temp unknown,
//   registers to their defaults, queue and output register empty
module spa_bus_frame_controller import sbfc_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    // request channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] rx_byte,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       out_kind,
    output logic [7:0] frame_cmd,
    output logic [7:0] frame_value,
    output logic [7:0] frame_check,
    output logic       check_ok,
    output logic       last_of_run,
    output logic [7:0] temp_half_deg,
    output logic       temp_known,
    output logic [7:0] bath_state,
    output logic [7:0] status_a,
    output logic [7:0] status_b,
    output logic [7:0] status_c,
    // register write port
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    job_t q_job;
    job_t head_job;
    res_t res;

    // register writes, masked to each register's width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TX_EN:       cfg_next.tx_en          = cfg_data[0];
                REG_HOLD_EN:     cfg_next.hold_en        = cfg_data[0];
                REG_TARGET_EN:   cfg_next.target_en      = cfg_data[0];
                REG_BEAT_EN:     cfg_next.beat_en        = cfg_data[0];
                REG_WANT_FILTER: cfg_next.want_filter    = cfg_data[0];
                REG_WANT_HEATER: cfg_next.want_heater    = cfg_data[0];
                REG_WANT_BUBBLE: cfg_next.want_bubbles   = cfg_data;
                REG_TARGET_C:    cfg_next.target_celsius = cfg_data[6:0];
                default:         cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tx_en          <= 1'b1;
            cfg_reg.hold_en        <= 1'b1;
            cfg_reg.target_en      <= 1'b1;
            cfg_reg.beat_en        <= 1'b1;
            cfg_reg.want_filter    <= 1'b0;
            cfg_reg.want_heater    <= 1'b0;
            cfg_reg.want_bubbles   <= 8'd0;
            cfg_reg.target_celsius <= TARGET_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: framer, status tracking, heater decision
    sbfc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .rx_byte  (rx_byte),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    // decouples the framer from the frame sequencer
    sbfc_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_job (head_job)
    );

    // back end: one result frame per cycle into the output register while not stalled
    sbfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .empty     (q_empty),
        .head_job  (head_job),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    // result fields
    assign out_kind      = res.out_kind;
    assign frame_cmd     = res.cmd;
    assign frame_value   = res.value;
    assign frame_check   = res.check;
    assign check_ok      = res.ok;
    assign last_of_run   = res.last;
    assign temp_half_deg = res.status.temp;
    assign temp_known    = res.status.temp_known;
    assign bath_state    = res.status.bath;
    assign status_a      = res.status.stat_a;
    assign status_b      = res.status.stat_b;
    assign status_c      = res.status.stat_c;

endmodule

// ===== sv/sbfc_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the spa bus frame controller, bound to the top level
module sbfc_checker import sbfc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       out_kind,
    input logic [7:0] frame_cmd,
    input logic [7:0] frame_value,
    input logic [7:0] frame_check,
    input logic       check_ok,
    input logic       last_of_run
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_cmd)
            && $stable(frame_value) && $stable(out_kind) && $stable(last_of_run))
        else $error("stalled result changed");

    // transmit frames carry a good computed checksum
    a_tx_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == OUT_KIND_TX |->
            check_ok && frame_check == frame_sum(frame_cmd, frame_value))
        else $error("bad transmit checksum");

    // a frame report is the only result of its byte
    a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == OUT_KIND_REPORT |-> last_of_run)
        else $error("report not marked last");

    // a hold sequence ends on bubbles, target or heartbeat
    a_tx_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == OUT_KIND_TX && last_of_run |->
            frame_cmd == CMD_BUBBLES || frame_cmd == CMD_TARGET || frame_cmd == CMD_BEAT)
        else $error("hold sequence ended early");

    // a received frame never reports the start byte as its checksum
    a_no_start_check: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == OUT_KIND_REPORT |-> frame_check != START_BYTE)
        else $error("start byte reported as checksum");

endmodule

bind spa_bus_frame_controller sbfc_checker u_sbfc_checker (.*);

// ===== tb/spa_bus_frame_controller_tb.sv =====
`timescale 1ns / 1ps
// testbench for the spa bus frame controller: directed and random requests against a predictor
module spa_bus_frame_controller_tb;
    import sbfc_pkg::*;

    // cycles to let the block settle once every expected frame has come out
    localparam int DRAIN_CYCLES = 20;
    // input requests per random register setting
    localparam int ITEMS_PER_SETTING = 62;

    // where the deframer stands: hunting, then waiting for command, value, checksum
    typedef enum logic [3:0]
    {
        POS_HUNT  = 4'b0001,
        POS_CMD   = 4'b0010,
        POS_VALUE = 4'b0100,
        POS_CHECK = 4'b1000
    } rx_pos_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       kind = KIND_BYTE;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       out_kind;
    logic [7:0] frame_cmd;
    logic [7:0] frame_value;
    logic [7:0] frame_check;
    logic       check_ok;
    logic       last_of_run;
    logic [7:0] temp_half_deg;
    logic       temp_known;
    logic [7:0] bath_state;
    logic [7:0] status_a;
    logic [7:0] status_b;
    logic [7:0] status_c;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = 3'd0;
    logic [7:0] cfg_data = 8'h00;

    // idling in percent for each side, changed between phases of the random part
    int send_idle_pct = 23;
    int stall_pct = 74;
    int fail_count = 0;

    // predictor state: registers, deframer position and the status the bus has reported
    cfg_t       regs;
    rx_pos_t    rx_pos;
    logic [7:0] rx_cmd;
    logic [7:0] rx_value;
    status_t    bus_state;

    // frames the block owes us, oldest first
    res_t frames_due[$];

    spa_bus_frame_controller i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_kind      (out_kind),
        .frame_cmd     (frame_cmd),
        .frame_value   (frame_value),
        .frame_check   (frame_check),
        .check_ok      (check_ok),
        .last_of_run   (last_of_run),
        .temp_half_deg (temp_half_deg),
        .temp_known    (temp_known),
        .bath_state    (bath_state),
        .status_a      (status_a),
        .status_b      (status_b),
        .status_c      (status_c),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // ---------------------------------------------------------------- predictor

    function automatic void reset_model();
        regs.tx_en          = 1'b1;
        regs.hold_en        = 1'b1;
        regs.target_en      = 1'b1;
        regs.beat_en        = 1'b1;
        regs.want_filter    = 1'b0;
        regs.want_heater    = 1'b0;
        regs.want_bubbles   = 8'd0;
        regs.target_celsius = TARGET_RESET;
        rx_pos              = POS_HUNT;
        rx_cmd              = 8'h00;
        rx_value            = 8'h00;
        bus_state.temp       = 8'h00;
        bus_state.temp_known = 1'b0;
        bus_state.bath       = STATUS_NONE;
        bus_state.stat_a     = STATUS_NONE;
        bus_state.stat_b     = STATUS_NONE;
        bus_state.stat_c     = STATUS_NONE;
    endfunction

    // register writes keep only the bits the register holds
    function automatic void apply_reg(logic [2:0] idx, logic [7:0] data);
        case (idx)
            REG_TX_EN:       regs.tx_en          = data[0];
            REG_HOLD_EN:     regs.hold_en        = data[0];
            REG_TARGET_EN:   regs.target_en      = data[0];
            REG_BEAT_EN:     regs.beat_en        = data[0];
            REG_WANT_FILTER: regs.want_filter    = data[0];
            REG_WANT_HEATER: regs.want_heater    = data[0];
            REG_WANT_BUBBLE: regs.want_bubbles   = data;
            REG_TARGET_C:    regs.target_celsius = data[6:0];
            default: ;
        endcase
    endfunction

    // every frame carries the status as it stands after the request that caused it
    function automatic void queue_frame(logic okind, logic [7:0] cmd, logic [7:0] value,
                                        logic [7:0] check, logic ok);
        res_t r;
        r.out_kind = okind;
        r.cmd      = cmd;
        r.value    = value;
        r.check    = check;
        r.ok       = ok;
        r.last     = 1'b0;
        r.status   = bus_state;
        frames_due = {frames_due, r};
    endfunction

    function automatic void tx_frame(logic [7:0] cmd, logic [7:0] value);
        logic [7:0] sum;
        sum = START_BYTE + cmd + value;
        queue_frame(OUT_KIND_TX, cmd, value, sum, 1'b1);
    endfunction

    function automatic void predict_frames(logic k, logic [7:0] b);
        int         first;
        logic [7:0] sum;
        logic       ok;
        logic       filter;
        logic       heater;
        res_t       tail;
        first = frames_due.size();
        if (k == KIND_BYTE)
        begin
            if (b == START_BYTE)
            begin
                // a start byte restarts the frame wherever it lands
                rx_pos = POS_CMD;
            end
            else
            begin
                case (rx_pos)
                    POS_CMD:
                    begin
                        rx_cmd = b;
                        rx_pos = POS_VALUE;
                    end
                    POS_VALUE:
                    begin
                        rx_value = b;
                        rx_pos   = POS_CHECK;
                    end
                    POS_CHECK:
                    begin
                        sum = START_BYTE + rx_cmd + rx_value;
                        ok  = (sum == b);
                        // only frames with a good checksum touch the status
                        if (ok)
                        begin
                            case (rx_cmd)
                                CMD_TEMP:
                                begin
                                    bus_state.temp       = rx_value;
                                    bus_state.temp_known = 1'b1;
                                end
                                CMD_BATH:   bus_state.bath   = rx_value;
                                CMD_STAT_A: bus_state.stat_a = rx_value;
                                CMD_STAT_B: bus_state.stat_b = rx_value;
                                CMD_STAT_C: bus_state.stat_c = rx_value;
                                default: ;
                            endcase
                        end
                        rx_pos = POS_HUNT;
                        queue_frame(OUT_KIND_REPORT, rx_cmd, rx_value, b, ok);
                    end
                    default: rx_pos = POS_HUNT;  // stray byte while hunting is dropped
                endcase
            end
        end
        else if (regs.tx_en && regs.hold_en)
        begin
            filter = regs.want_filter || regs.want_heater || (regs.want_bubbles != 8'd0);
            // half-degree reading against twice the whole-degree target
            heater = regs.want_heater && filter &&
                     (!bus_state.temp_known || (bus_state.temp < {regs.target_celsius, 1'b0}));
            tx_frame(CMD_FILTER, {7'd0, filter});
            tx_frame(CMD_HEATER, {7'd0, heater});
            tx_frame(CMD_BUBBLES, regs.want_bubbles);
            if (regs.target_en)
                tx_frame(CMD_TARGET, {1'b0, regs.target_celsius});
            if (regs.beat_en)
                tx_frame(CMD_BEAT, 8'h00);
        end
        if (frames_due.size() > first)
        begin
            tail = frames_due[frames_due.size() - 1];
            tail.last = 1'b1;
            frames_due[frames_due.size() - 1] = tail;
        end
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endfunction

    // outputs are sampled at the edge where the handshake completes
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (frames_due.size() == 0)
            begin
                $error("unexpected frame: cmd %h value %h", frame_cmd, frame_value);
                fail_count++;
            end
            else
            begin
                want = frames_due.pop_front();
                check_field("out_kind", want.out_kind, out_kind);
                check_field("frame_cmd", want.cmd, frame_cmd);
                check_field("frame_value", want.value, frame_value);
                check_field("frame_check", want.check, frame_check);
                check_field("check_ok", want.ok, check_ok);
                check_field("last_of_run", want.last, last_of_run);
                check_field("temp_half_deg", want.status.temp, temp_half_deg);
                check_field("temp_known", want.status.temp_known, temp_known);
                check_field("bath_state", want.status.bath, bath_state);
                check_field("status_a", want.status.stat_a, status_a);
                check_field("status_b", want.status.stat_b, status_b);
                check_field("status_c", want.status.stat_c, status_c);
            end
        end
    end

    // ---------------------------------------------------------------- driving

    // one request; returns at the accepting edge, valid left high unless a gap is drawn
    task automatic send_request(logic k, logic [7:0] b);
        int gap;
        in_valid <= 1'b1;
        kind     <= k;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_frames(k, b);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_frame(logic [7:0] cmd, logic [7:0] value, logic [7:0] check);
        send_request(KIND_BYTE, START_BYTE);
        send_request(KIND_BYTE, cmd);
        send_request(KIND_BYTE, value);
        send_request(KIND_BYTE, check);
    endtask

    task automatic send_good_frame(logic [7:0] cmd, logic [7:0] value);
        logic [7:0] sum;
        sum = START_BYTE + cmd + value;
        send_frame(cmd, value, sum);
    endtask

    // drop valid, wait for every owed frame, then let trailing no-result jobs clear
    task automatic wait_idle();
        if (in_valid)
            in_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(logic [7:0] tx, logic [7:0] hold, logic [7:0] tgt_en,
                              logic [7:0] beat, logic [7:0] filt, logic [7:0] heat,
                              logic [7:0] bubbles, logic [7:0] target);
        write_reg(REG_TX_EN, tx);
        write_reg(REG_HOLD_EN, hold);
        write_reg(REG_TARGET_EN, tgt_en);
        write_reg(REG_BEAT_EN, beat);
        write_reg(REG_WANT_FILTER, filt);
        write_reg(REG_WANT_HEATER, heat);
        write_reg(REG_WANT_BUBBLE, bubbles);
        write_reg(REG_TARGET_C, target);
    endtask

    // ---------------------------------------------------------------- tests

    // reset defaults: five frames, everything off, target 38
    task automatic test_hold_defaults();
        send_request(KIND_HOLD, 8'hFF);
        wait_idle();
    endtask

    task automatic test_framing();
        // stray byte while hunting
        send_request(KIND_BYTE, 8'h5A);
        // bad checksum, status untouched
        send_frame(CMD_STAT_A, 8'h00, 8'h00);
        // start byte in the checksum slot restarts, the next frame lands
        send_request(KIND_BYTE, START_BYTE);
        send_request(KIND_BYTE, CMD_BATH);
        send_request(KIND_BYTE, 8'h00);
        send_good_frame(CMD_BATH, 8'h00);
        // good frame with a command nothing listens to
        send_good_frame(8'hFF, 8'hFF);
        wait_idle();
    endtask

    // heater on while temperature unknown, off at the exact threshold 254 vs 2 * 127
    task automatic test_heater_threshold();
        set_config(8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h7F);
        send_request(KIND_HOLD, 8'h00);
        send_good_frame(CMD_TEMP, 8'hFE);
        send_request(KIND_HOLD, 8'h00);
        wait_idle();
    endtask

    // upper data bits must be ignored, so bit 0 low disables
    task automatic test_hold_disabled();
        write_reg(REG_TX_EN, 8'hFE);
        send_request(KIND_HOLD, 8'h00);
        wait_idle();
        write_reg(REG_TX_EN, 8'h01);
        write_reg(REG_HOLD_EN, 8'h00);
        send_request(KIND_HOLD, 8'h00);
        wait_idle();
    endtask

    task automatic randomize_config();
        logic [7:0] d_tx;
        logic [7:0] d_hold;
        logic [7:0] d_bub;
        logic [7:0] d_tgt;
        // keep transmit mostly on so holds produce frames
        d_tx    = 8'($urandom);
        d_tx[0] = ($urandom_range(0, 7) != 0);
        d_hold    = 8'($urandom);
        d_hold[0] = ($urandom_range(0, 7) != 0);
        case ($urandom_range(0, 3))
            0:       d_bub = 8'h00;
            1:       d_bub = 8'hFF;
            default: d_bub = 8'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       d_tgt = 8'h00;
            1:       d_tgt = 8'h7F;
            2:       d_tgt = 8'hFF;
            default: d_tgt = 8'($urandom);
        endcase
        set_config(d_tx, d_hold, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   d_bub, d_tgt);
    endtask

    // mostly well-formed frames with random content, some holds, noise and cut-off frames
    task automatic random_burst(int n_items);
        int         sent;
        int         pick;
        int         tail_len;
        logic [7:0] cmd;
        logic [7:0] value;
        logic [7:0] check;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                case ($urandom_range(0, 7))
                    0, 5:    cmd = CMD_TEMP;
                    1:       cmd = CMD_BATH;
                    2:       cmd = CMD_STAT_A;
                    3:       cmd = CMD_STAT_B;
                    4:       cmd = CMD_STAT_C;
                    default: cmd = 8'($urandom);
                endcase
                if ($urandom_range(0, 3) == 0)
                    value = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                else
                    value = 8'($urandom);
                check = START_BYTE + cmd + value;
                if ($urandom_range(0, 4) == 0)
                    check = 8'($urandom);
                send_frame(cmd, value, check);
                sent += 4;
            end
            else if (pick < 82)
            begin
                send_request(KIND_HOLD, 8'($urandom));
                sent++;
            end
            else if (pick < 92)
            begin
                // noise, mostly dropped by the framer
                send_request(KIND_BYTE, 8'($urandom));
                sent++;
            end
            else
            begin
                // frame cut short, the next start byte abandons it
                tail_len = $urandom_range(1, 2);
                send_request(KIND_BYTE, START_BYTE);
                repeat (tail_len) send_request(KIND_BYTE, 8'($urandom));
                sent += 1 + tail_len;
            end
        end
    endtask

    task automatic test_random_traffic();
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 23;
                    stall_pct     = 74;
                end
                1:
                begin
                    send_idle_pct = 74;
                    stall_pct     = 23;
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            for (int s = 0; s < 2; s++)
            begin
                randomize_config();
                random_burst(ITEMS_PER_SETTING);
                wait_idle();
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        reset_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_hold_defaults();
        test_framing();
        test_heater_threshold();
        test_hold_disabled();
        test_random_traffic();
        if (fail_count == 0 && frames_due.size() == 0)
            $display("spa_bus_frame_controller regression: pass");
        else
            $display("spa_bus_frame_controller regression: fail");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #1000000;
        $display("spa_bus_frame_controller regression: fail");
        $finish;
    end

endmodule

// ===== spa_bus_frame_controller.f =====
sv/sbfc_pkg.sv
sv/sbfc_front.sv
sv/sbfc_queue.sv
sv/sbfc_back.sv
sv/spa_bus_frame_controller.sv
sv/sbfc_checker.sv
tb/spa_bus_frame_controller_tb.sv
